// File: rtl/core/lts_pkg.sv
// Shared types, codes and scan functions of the token scanner.
`timescale 1ns / 1ps

package lts_pkg;

  // Token kinds on the result channel
  localparam logic [3:0] K_END       = 4'd0;
  localparam logic [3:0] K_INT       = 4'd1;
  localparam logic [3:0] K_DBL       = 4'd2;
  localparam logic [3:0] K_KW        = 4'd3;
  localparam logic [3:0] K_SYM       = 4'd4;
  localparam logic [3:0] K_STR       = 4'd5;
  localparam logic [3:0] K_CMT       = 4'd6;
  localparam logic [3:0] K_LPAREN    = 4'd7;
  localparam logic [3:0] K_RPAREN    = 4'd8;
  localparam logic [3:0] K_LBRACE    = 4'd9;
  localparam logic [3:0] K_RBRACE    = 4'd10;
  localparam logic [3:0] K_LBRACKET  = 4'd11;
  localparam logic [3:0] K_RBRACKET  = 4'd12;
  localparam logic [3:0] K_HASHBRACE = 4'd13;
  localparam logic [3:0] K_UNEXP     = 4'd14;

  // Scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_INT     = 4'd1;
  localparam logic [3:0] M_DBL     = 4'd2;
  localparam logic [3:0] M_KW      = 4'd3;
  localparam logic [3:0] M_SYM     = 4'd4;
  localparam logic [3:0] M_SPECIAL = 4'd5;
  localparam logic [3:0] M_STR     = 4'd6;
  localparam logic [3:0] M_ESC     = 4'd7;
  localparam logic [3:0] M_CMT     = 4'd8;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Results of one byte, and the queue that carries them
  localparam int MAX_ITEMS = 6;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic       has;
    logic       last;
  } item_t;

  typedef struct packed {
    item_t [MAX_ITEMS-1:0] items;
    logic  [CNT_W-1:0]     cnt;
  } bundle_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] held_char;
    logic       held_valid;
  } scan_t;

  typedef struct packed {
    scan_t   st;
    bundle_t bun;
  } step_t;

  typedef struct packed {
    logic    push;
    bundle_t bun;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  function automatic logic char_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic char_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic char_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_COMMA;
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return char_alpha(c) || char_digit(c) || c == CH_MINUS || c == CH_UNDER;
  endfunction

  function automatic logic char_punct(logic [7:0] c);
    logic r;
    unique case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h3D, 8'h2D, 8'h5E,
      8'h7E, 8'h7C, 8'h2B, 8'h2A, 8'h2F, 8'h3F, 8'h3C, 8'h3E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] bracket_kind(logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h5B:   k = K_LBRACKET;
      8'h5D:   k = K_RBRACKET;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic step_t emit_text(step_t s, logic [3:0] k, logic [7:0] c);
    s.bun.items[s.bun.cnt] = '{kind: k, ch: c, has: 1'b1, last: 1'b0};
    s.bun.cnt = s.bun.cnt + 1'b1;
    return s;
  endfunction

  function automatic step_t emit_term(step_t s, logic [3:0] k);
    s.bun.items[s.bun.cnt] = '{kind: k, ch: CH_NUL, has: 1'b0, last: 1'b1};
    s.bun.cnt = s.bun.cnt + 1'b1;
    return s;
  endfunction

  // Byte between tokens, nothing held
  function automatic step_t scan_start(step_t s, logic [7:0] b);
    logic [3:0] k;
    k = bracket_kind(b);
    s.st.mode = M_IDLE;
    if (b == CH_NUL) begin
      s = emit_term(s, K_END);
    end else if (char_digit(b)) begin
      s.st.mode = M_INT;
      s = emit_text(s, K_INT, b);
    end else if (b == CH_COLON) begin
      s.st.mode = M_KW;
      s = emit_text(s, K_KW, b);
    end else if (char_alpha(b)) begin
      s.st.mode = M_SYM;
      s = emit_text(s, K_SYM, b);
    end else if (b == CH_HASH || b == CH_MINUS || b == CH_SLASH) begin
      s.st.held_char  = b;
      s.st.held_valid = 1'b1;
    end else if (k != K_END) begin
      s = emit_text(s, k, b);
      s = emit_term(s, k);
    end else if (b == CH_QUOTE) begin
      s.st.mode = M_STR;
    end else if (char_punct(b)) begin
      s.st.mode = M_SPECIAL;
      s = emit_text(s, K_SYM, b);
    end else if (!char_blank(b)) begin
      s = emit_term(s, K_UNEXP);
    end
    return s;
  endfunction

  // Byte inside the current token
  function automatic step_t scan_advance(step_t s, logic [7:0] b);
    unique case (s.st.mode)
      M_INT: begin
        if (char_digit(b)) begin
          s = emit_text(s, K_INT, b);
        end else if (b == CH_DOT) begin
          s.st.mode = M_DBL;
          s = emit_text(s, K_DBL, b);
        end else begin
          s = emit_term(s, K_INT);
          s = scan_start(s, b);
        end
      end
      M_DBL: begin
        if (char_digit(b)) begin
          s = emit_text(s, K_DBL, b);
        end else begin
          s = emit_term(s, K_DBL);
          s = scan_start(s, b);
        end
      end
      M_KW: begin
        if (is_word(b)) begin
          s = emit_text(s, K_KW, b);
        end else begin
          s = emit_term(s, K_KW);
          s = scan_start(s, b);
        end
      end
      M_SYM: begin
        if (is_word(b)) begin
          s = emit_text(s, K_SYM, b);
        end else begin
          s = emit_term(s, K_SYM);
          s = scan_start(s, b);
        end
      end
      M_SPECIAL: begin
        if (char_punct(b)) begin
          s = emit_text(s, K_SYM, b);
        end else begin
          s = emit_term(s, K_SYM);
          s = scan_start(s, b);
        end
      end
      M_STR: begin
        if (b == CH_QUOTE) begin
          s.st.mode = M_IDLE;
          s = emit_term(s, K_STR);
        end else if (b == CH_NUL) begin
          s = emit_term(s, K_STR);
          s = scan_start(s, b);
        end else begin
          if (b == CH_BSLASH) s.st.mode = M_ESC;
          s = emit_text(s, K_STR, b);
        end
      end
      M_ESC: begin
        if (b == CH_NUL) begin
          s = emit_term(s, K_STR);
          s = scan_start(s, b);
        end else begin
          s.st.mode = M_STR;
          s = emit_text(s, K_STR, b);
        end
      end
      M_CMT: begin
        if (b == CH_LF || b == CH_NUL) begin
          s = emit_term(s, K_CMT);
          s = scan_start(s, b);
        end else begin
          s = emit_text(s, K_CMT, b);
        end
      end
      default: s = scan_start(s, b);
    endcase
    return s;
  endfunction

  // Settle what the held byte starts, now that the next byte is known
  function automatic step_t scan_resolve(step_t s, logic [7:0] b);
    logic [7:0] h;
    h = s.st.held_char;
    s.st.held_valid = 1'b0;
    s.st.held_char  = CH_NUL;
    if (h == CH_HASH && b == CH_LBRACE) begin
      s.st.mode = M_IDLE;
      s = emit_text(s, K_HASHBRACE, h);
      s = emit_text(s, K_HASHBRACE, b);
      s = emit_term(s, K_HASHBRACE);
    end else if (h == CH_MINUS && char_digit(b)) begin
      s.st.mode = M_INT;
      s = emit_text(s, K_INT, h);
      s = emit_text(s, K_INT, b);
    end else if (h == CH_SLASH && b == CH_SLASH) begin
      s.st.mode = M_CMT;
    end else begin
      s.st.mode = M_SPECIAL;
      s = emit_text(s, K_SYM, h);
      s = scan_advance(s, b);
    end
    return s;
  endfunction

  function automatic step_t scan_step(scan_t st, logic [7:0] b);
    step_t s;
    s.st  = st;
    s.bun = '0;
    if (st.held_valid) s = scan_resolve(s, b);
    else               s = scan_advance(s, b);
    return s;
  endfunction

endpackage

// File: rtl/core/lts_front.sv
// Front end: accepts source bytes, classifies them and writes result bundles to the queue.
`timescale 1ns / 1ps

module lts_front
  import lts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  q_stat_t     q_stat,
  output q_wr_t       q_wr
);

  scan_t st;
  step_t nxt;
  logic  accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign nxt      = scan_step(st, text_byte);

  // Drop empty bundles (skipped whitespace, held lookahead byte)
  assign q_wr.push = accept && (nxt.bun.cnt != '0);
  assign q_wr.bun  = nxt.bun;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: M_IDLE, held_char: CH_NUL, held_valid: 1'b0};
    end else if (accept) begin
      st <= nxt.st;
    end
  end

endmodule

// File: rtl/core/lts_queue.sv
// Short bundle queue between the front and back ends.
`timescale 1ns / 1ps

module lts_queue
  import lts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_wr_t   q_wr,
  input  logic    pop,
  output bundle_t head,
  output q_stat_t q_stat
);

  bundle_t           entries [QDEPTH];
  logic [QAW-1:0]    wr_ptr;
  logic [QAW-1:0]    rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full     = (count == QCNT_W'(QDEPTH));
  assign q_stat.nonempty = (count != '0);
  assign head            = entries[rd_ptr];
  assign do_push         = q_wr.push && !q_stat.full;
  assign do_pop          = pop && q_stat.nonempty;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= q_wr.bun;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/core/lts_back.sv
// Back end: walks each queued bundle, one item word per cycle unless stalled.
`timescale 1ns / 1ps

module lts_back
  import lts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] token_kind,
  output logic [7:0] text_char,
  output logic       has_char,
  output logic       token_last
);

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             at_end;
  item_t            cur;

  assign load   = q_stat.nonempty && (!out_valid || !out_stall);
  assign cur    = head.items[idx];
  assign at_end = (idx == head.cnt - 1'b1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind <= cur.kind;
      text_char  <= cur.ch;
      has_char   <= cur.has;
      token_last <= cur.last;
    end
  end

endmodule

// File: rtl/core/lisp_token_scanner_top.sv
// Top level of the streaming Lisp token scanner.
//
// Input channel: one source byte per word on text_byte, taken at an edge where
// in_valid is high and in_stall is low. A zero byte ends the text; bytes after
// it start a new text from the between-tokens state.
// Output channel: one word per token text byte (has_char set) followed by one
// terminator word (token_last set) whose token_kind is the final kind. Words
// are taken at an edge where out_valid is high and out_stall is low.
// Order: with an empty queue, the bundle caused by a byte is written to the queue at
// the edge that takes the byte, and the output register then loads its first word
// from the queue.
// Throughput: one byte per cycle into the front end while the queue has room;
// one output word per cycle from the back end while out_stall is low. A byte
// yields zero to four words, so bursts of brackets or token ends fill the
// 4-bundle queue and then in_stall rises until the back end catches up.
// Output stall: the output register holds its word; the queue absorbs further
// bundles and, once full, stalls the input.
// Reset (rst, synchronous): scan state returns to between tokens with no held
// byte, the queue empties and out_valid drops.
`timescale 1ns / 1ps

module lisp_token_scanner_top
  import lts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] token_kind,
  output logic [7:0] text_char,
  output logic       has_char,
  output logic       token_last
);

  q_wr_t   q_wr;
  q_stat_t q_stat;
  bundle_t head;
  logic    pop;

  // Front end: classify each byte and write its result bundle
  lts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .q_stat    (q_stat),
    .q_wr      (q_wr)
  );

  // Decouple the two sides
  lts_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Back end: serialize bundles onto the output channel
  lts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_kind (token_kind),
    .text_char  (text_char),
    .has_char   (has_char),
    .token_last (token_last)
  );

endmodule

// File: rtl/core/lts_checker.sv
// Port-level assertions for the token scanner, bound to the top level.
`timescale 1ns / 1ps

module lts_checker
  import lts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] text_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] token_kind,
  input logic [7:0] text_char,
  input logic       has_char,
  input logic       token_last
);

  // Stalled input word stays up and does not change
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(text_byte))
    else $error("stalled input word changed");

  // Stalled output word stays up and does not change
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(text_char)
                               && $stable(has_char) && $stable(token_last))
    else $error("stalled output word changed");

  // Every word is either a text byte or a terminator
  a_word_type: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_char != token_last))
    else $error("word is neither text nor terminator");

  // Text bytes never carry the end or unexpected kinds
  a_text_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_char |-> (token_kind != K_END) && (token_kind != K_UNEXP))
    else $error("text word with end or unexpected kind");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind lisp_token_scanner_top lts_checker u_lts_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .text_byte  (text_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .token_kind (token_kind),
  .text_char  (text_char),
  .has_char   (has_char),
  .token_last (token_last)
);
